// ===== src/scfd_pkg.sv =====
package scfd_pkg;

   localparam int FRAME_BYTES = 1024;
   localparam int PAYLOAD_MAX = 1017;
   localparam int ADDR_W      = $clog2(FRAME_BYTES);
   localparam int FILL_W      = ADDR_W + 1;
   localparam int IDX_W       = 10;
   localparam int LEN_W       = 10;
   localparam int POS_W       = (FILL_W > IDX_W + 1) ? FILL_W : IDX_W + 1;
   localparam int HDR_BYTES   = 5;
   localparam int HDR_IDX_W   = $clog2(HDR_BYTES);
   localparam int CRC_BYTES   = 2;
   localparam int SUM_W       = 17;

   localparam logic [7:0]  SLIP_END     = 8'hC0;
   localparam logic [7:0]  SLIP_ESC     = 8'hDB;
   localparam logic [7:0]  SLIP_ESC_END = 8'hDC;
   localparam logic [7:0]  SLIP_ESC_ESC = 8'hDD;
   localparam logic [15:0] CRC_INIT     = 16'hFFFF;
   localparam logic [15:0] CRC_POLY     = 16'h1021;
   localparam logic [15:0] CRC_TOP      = 16'h8000;

   typedef enum logic {
      REQ_FEED = 1'b0,
      REQ_READ = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic              frame_ready;
      logic [7:0]        frame_type;
      logic [7:0]        frame_flags;
      logic [7:0]        frame_seq;
      logic [LEN_W-1:0]  payload_len;
      logic [31:0]       dropped_count;
      logic              read_hit;
   } stage_type;

   typedef struct packed {
      logic              frame_ready;
      logic [7:0]        frame_type;
      logic [7:0]        frame_flags;
      logic [7:0]        frame_seq;
      logic [LEN_W-1:0]  payload_len;
      logic [31:0]       dropped_count;
      logic [7:0]        read_data;
   } rsp_word_type;

   // byte-wide crc-16, msb first
   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== src/scfd_req_if.sv =====
interface scfd_req_if;
   logic                       valid;
   logic                       ready;
   logic                       req_type;
   logic [7:0]                 wire_byte;
   logic [scfd_pkg::IDX_W-1:0] read_index;

   modport source (output valid, output req_type, output wire_byte, output read_index,
                   input ready);
   modport sink (input valid, input req_type, input wire_byte, input read_index,
                 output ready);
endinterface

// ===== src/scfd_rsp_if.sv =====
interface scfd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       frame_ready;
   logic [7:0]                 frame_type;
   logic [7:0]                 frame_flags;
   logic [7:0]                 frame_seq;
   logic [scfd_pkg::LEN_W-1:0] payload_len;
   logic [31:0]                dropped_count;
   logic [7:0]                 read_data;

   modport source (output valid, output frame_ready, output frame_type, output frame_flags,
                   output frame_seq, output payload_len, output dropped_count,
                   output read_data, input ready);
   modport sink (input valid, input frame_ready, input frame_type, input frame_flags,
                 input frame_seq, input payload_len, input dropped_count,
                 input read_data, output ready);
endinterface

// ===== src/scfd_ram.sv =====
module scfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/slip_crc_frame_decoder.sv =====
// SLIP deframer with CRC-16 check. Takes one word per cycle, feed or read alike, unless
// rsp_chan stalls, via s1_ff and out_ff; the rate is set by the frame buffer's one write and
// one registered read port per cycle and a byte-wide CRC fold. There is no clearing pass
// after reset. A frame is a five-byte header (type, flags, seq, length low/high), the payload
// and a little-endian CRC-16 (poly 0x1021, init 0xFFFF) over header and payload; bad frames
// only bump the wrapping drop count. A read word returns payload byte read_index of the last
// buffered frame (0 beyond the buffer) and is only meaningful until the next byte is fed.
module slip_crc_frame_decoder (
   input logic        clock,
   input logic        reset,
   scfd_req_if.sink   req_chan,
   scfd_rsp_if.source rsp_chan
);
   import scfd_pkg::*;

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              esc_ff, esc_in;
   logic              disc_ff, disc_in;
   logic [31:0]       drop_ff, drop_in;
   logic [15:0]       crc_ff, crc_in;
   logic [7:0]        hist0_ff, hist1_ff;
   logic [7:0]        hdr_ff [HDR_BYTES];

   logic              s1_valid_ff;
   stage_type         s1_ff, s1_in;
   logic              out_valid_ff;
   rsp_word_type      out_ff;

   logic              accept, move;
   req_kind_type      kind;
   logic              store_req, wr_en, hdr_we;
   logic [7:0]        data;
   logic [15:0]       frame_len;
   logic [SUM_W-1:0]  frame_sum;
   logic              frame_empty, frame_bad;
   logic [POS_W-1:0]  pos;
   logic              rd_en;
   logic [7:0]        rd_data;

   assign move            = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready  = !s1_valid_ff || move;
   assign accept          = req_chan.valid && req_chan.ready;
   assign kind            = req_kind_type'(req_chan.req_type);

   assign pos   = POS_W'(HDR_BYTES) + POS_W'(req_chan.read_index);
   assign rd_en = accept && (kind == REQ_READ);

   assign frame_len   = {hdr_ff[4], hdr_ff[3]};
   assign frame_sum   = SUM_W'(frame_len) + SUM_W'(HDR_BYTES + CRC_BYTES);
   assign frame_empty = (fill_ff == '0) && !disc_ff && !esc_ff;
   assign frame_bad   = disc_ff || esc_ff
                     || (fill_ff < FILL_W'(HDR_BYTES + CRC_BYTES))
                     || (frame_len > 16'(PAYLOAD_MAX))
                     || (frame_sum != SUM_W'(fill_ff))
                     || ({hist0_ff, hist1_ff} != crc_ff);

   always_comb begin
      fill_in   = fill_ff;
      esc_in    = esc_ff;
      disc_in   = disc_ff;
      drop_in   = drop_ff;
      crc_in    = crc_ff;
      store_req = 1'b0;
      wr_en     = 1'b0;
      hdr_we    = 1'b0;
      data      = req_chan.wire_byte;
      s1_in     = '0;

      if (accept && kind == REQ_FEED) begin
         if (req_chan.wire_byte == SLIP_END) begin
            fill_in = '0;
            esc_in  = 1'b0;
            disc_in = 1'b0;
            crc_in  = CRC_INIT;
            if (!frame_empty) begin
               if (frame_bad) begin
                  drop_in = drop_ff + 32'd1;
               end else begin
                  s1_in.frame_ready = 1'b1;
                  s1_in.frame_type  = hdr_ff[0];
                  s1_in.frame_flags = hdr_ff[1];
                  s1_in.frame_seq   = hdr_ff[2];
                  s1_in.payload_len = frame_len[LEN_W-1:0];
               end
            end
         end else begin
            if (esc_ff) begin
               esc_in = 1'b0;
               if (req_chan.wire_byte == SLIP_ESC_END) begin
                  data      = SLIP_END;
                  store_req = 1'b1;
               end else if (req_chan.wire_byte == SLIP_ESC_ESC) begin
                  data      = SLIP_ESC;
                  store_req = 1'b1;
               end else begin
                  disc_in = 1'b1;
               end
            end else if (req_chan.wire_byte == SLIP_ESC) begin
               esc_in = 1'b1;
            end else begin
               store_req = 1'b1;
            end

            if (store_req && !disc_ff) begin
               if (fill_ff == FILL_W'(FRAME_BYTES)) begin
                  disc_in = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  hdr_we  = fill_ff < FILL_W'(HDR_BYTES);
                  fill_in = fill_ff + FILL_W'(1);
                  // crc trails the fill by two bytes, so the crc field itself is left out
                  if (fill_ff >= FILL_W'(CRC_BYTES)) begin
                     crc_in = crc_fold(crc_ff, hist1_ff);
                  end
               end
            end
         end
      end

      s1_in.dropped_count = drop_in;
      s1_in.read_hit      = rd_en && (pos < POS_W'(FRAME_BYTES));
   end

   scfd_ram #(
      .WIDTH(8),
      .DEPTH(FRAME_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (data),
      .rd_en   (rd_en),
      .rd_addr (pos[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         esc_ff       <= 1'b0;
         disc_ff      <= 1'b0;
         drop_ff      <= '0;
         crc_ff       <= CRC_INIT;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         esc_ff  <= esc_in;
         disc_ff <= disc_in;
         drop_ff <= drop_in;
         crc_ff  <= crc_in;
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (move) begin
            s1_valid_ff <= 1'b0;
         end
         if (move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist0_ff <= data;
         hist1_ff <= hist0_ff;
      end
      if (hdr_we) begin
         hdr_ff[fill_ff[HDR_IDX_W-1:0]] <= data;
      end
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (move) begin
         out_ff.frame_ready   <= s1_ff.frame_ready;
         out_ff.frame_type    <= s1_ff.frame_type;
         out_ff.frame_flags   <= s1_ff.frame_flags;
         out_ff.frame_seq     <= s1_ff.frame_seq;
         out_ff.payload_len   <= s1_ff.payload_len;
         out_ff.dropped_count <= s1_ff.dropped_count;
         out_ff.read_data     <= s1_ff.read_hit ? rd_data : 8'h00;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.frame_ready   = out_ff.frame_ready;
   assign rsp_chan.frame_type    = out_ff.frame_type;
   assign rsp_chan.frame_flags   = out_ff.frame_flags;
   assign rsp_chan.frame_seq     = out_ff.frame_seq;
   assign rsp_chan.payload_len   = out_ff.payload_len;
   assign rsp_chan.dropped_count = out_ff.dropped_count;
   assign rsp_chan.read_data     = out_ff.read_data;

endmodule

// ===== src/scfd_checker.sv =====
module scfd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_frame_ready,
   input logic [scfd_pkg::LEN_W-1:0] rsp_payload_len,
   input logic [31:0]                rsp_dropped_count,
   input logic [7:0]                 rsp_read_data
);
   import scfd_pkg::*;

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_dropped_count) && $stable(rsp_frame_ready))
      else $error("stalled result changed");

   // a fresh result always comes from a word taken earlier and carried through s1_ff
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a matching request");

   // a good frame comes only from an end byte, never from a read
   a_frame_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_ready |->
         rsp_read_data == 8'h00 && rsp_payload_len <= LEN_W'(PAYLOAD_MAX))
      else $error("inconsistent frame report");

endmodule

bind slip_crc_frame_decoder scfd_checker u_scfd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_frame_ready   (rsp_chan.frame_ready),
   .rsp_payload_len   (rsp_chan.payload_len),
   .rsp_dropped_count (rsp_chan.dropped_count),
   .rsp_read_data     (rsp_chan.read_data)
);

// ===== tb/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import scfd_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_WORDS = 1200;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 10;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      req_kind_type     kind;
      logic [7:0]       data;
      logic [IDX_W-1:0] idx;
   } req_word_type;

   typedef enum logic [1:0] {
      ROW_WIRE, // raw wire byte, sent as it stands
      ROW_DATA, // frame byte, escaped on the wire
      ROW_CRC,  // crc of the frame bytes so far, escaped
      ROW_READ
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [9:0]   arg;
      logic         typed;
      rsp_word_type want;
   } dir_row_type;

   typedef enum logic [3:0] {
      FAULT_NONE,
      FAULT_CRC,
      FAULT_LEN,
      FAULT_BIG_LEN,
      FAULT_TRUNC,
      FAULT_SHORT,
      FAULT_BAD_ESC,
      FAULT_DANGLE,
      FAULT_EXTRA
   } fault_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   scfd_req_if req_bus ();
   scfd_rsp_if rsp_bus ();

   slip_crc_frame_decoder u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the deframer state
   logic [7:0]  store_mem [FRAME_BYTES];
   int unsigned fill_cnt   = 0;
   int unsigned store_top  = 0;
   bit          esc_seen   = 1'b0;
   bit          skipping   = 1'b0;
   logic [31:0] drop_tally = '0;
   logic [15:0] run_crc    = CRC_INIT;

   rsp_word_type pending_q [$];
   bit           typed_on = 1'b0;
   rsp_word_type typed_want;
   bit           calm = 1'b0;
   bit           reads_on = 1'b0;
   bit           hold_request = 1'b0;
   int           words_sent = 0;
   int           faults = 0;
   int           cycle_count = 0;

   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ d[i];
         c  = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   function automatic logic [15:0] crc_over(input logic [7:0] bytes_q [$]);
      logic [15:0] c;
      c = CRC_INIT;
      foreach (bytes_q[i]) begin
         c = crc_byte(c, bytes_q[i]);
      end
      return c;
   endfunction

   function automatic rsp_word_type decode_word(input req_word_type w);
      rsp_word_type r;
      int unsigned  pos, n;
      logic [15:0]  len, sum, tail;
      logic [7:0]   b;
      bit           ok, keep;
      r = '0;
      if (w.kind == REQ_READ) begin
         pos = HDR_BYTES + w.idx;
         if (pos < FRAME_BYTES) begin
            r.read_data = store_mem[pos];
         end
      end else if (w.data == SLIP_END) begin
         n   = fill_cnt;
         ok  = !skipping && !esc_seen;
         sum = run_crc;
         // an end on an empty, clean buffer is just a frame separator
         if (n != 0 || !ok) begin
            ok = ok && n >= HDR_BYTES + CRC_BYTES;
            if (ok) begin
               len = {store_mem[4], store_mem[3]};
               ok  = len <= PAYLOAD_MAX && n == HDR_BYTES + CRC_BYTES + len;
            end
            if (ok) begin
               tail = {store_mem[n-1], store_mem[n-2]};
               ok   = tail == sum;
            end
            if (ok) begin
               r.frame_ready = 1'b1;
               r.frame_type  = store_mem[0];
               r.frame_flags = store_mem[1];
               r.frame_seq   = store_mem[2];
               r.payload_len = len[LEN_W-1:0];
            end else begin
               drop_tally = drop_tally + 32'd1;
            end
         end
         fill_cnt = 0;
         skipping = 1'b0;
         esc_seen = 1'b0;
         run_crc  = CRC_INIT;
      end else begin
         b    = w.data;
         keep = 1'b1;
         if (esc_seen) begin
            esc_seen = 1'b0;
            if (b == SLIP_ESC_END) begin
               b = SLIP_END;
            end else if (b == SLIP_ESC_ESC) begin
               b = SLIP_ESC;
            end else begin
               skipping = 1'b1;
               keep     = 1'b0;
            end
         end else if (b == SLIP_ESC) begin
            esc_seen = 1'b1;
            keep     = 1'b0;
         end
         if (keep && !skipping) begin
            if (fill_cnt >= FRAME_BYTES) begin
               skipping = 1'b1;
            end else begin
               // crc runs two bytes behind so the trailer stays out of it
               if (fill_cnt >= CRC_BYTES) begin
                  run_crc = crc_byte(run_crc, store_mem[fill_cnt - CRC_BYTES]);
               end
               store_mem[fill_cnt] = b;
               fill_cnt = fill_cnt + 1;
               if (fill_cnt > store_top) begin
                  store_top = fill_cnt;
               end
            end
         end
      end
      r.dropped_count = drop_tally;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_word_type got, want;
      req_word_type w;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.frame_ready   = rsp_bus.frame_ready;
            got.frame_type    = rsp_bus.frame_type;
            got.frame_flags   = rsp_bus.frame_flags;
            got.frame_seq     = rsp_bus.frame_seq;
            got.payload_len   = rsp_bus.payload_len;
            got.dropped_count = rsp_bus.dropped_count;
            got.read_data     = rsp_bus.read_data;
            if (pending_q.size() == 0) begin
               faults++;
               if (faults <= MAX_REPORTS) begin
                  $display("unexpected result word at cycle %0d, drop=%0d",
                           cycle_count, got.dropped_count);
               end
            end else begin
               want = pending_q.pop_front();
               if (got.frame_ready !== want.frame_ready || got.frame_type !== want.frame_type ||
                   got.frame_flags !== want.frame_flags || got.frame_seq !== want.frame_seq ||
                   got.payload_len !== want.payload_len ||
                   got.dropped_count !== want.dropped_count ||
                   got.read_data !== want.read_data) begin
                  faults++;
                  if (faults <= MAX_REPORTS) begin
                     $display("mismatch cycle %0d:\n   want %p\n   got  %p",
                              cycle_count, want, got);
                  end
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            w.kind = req_kind_type'(req_bus.req_type);
            w.data = req_bus.wire_byte;
            w.idx  = req_bus.read_index;
            want   = decode_word(w);
            pending_q.push_back(typed_on ? typed_want : want);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side: random stalls plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(99) >= 9);
         end
      end
   end

   function automatic req_word_type mk_feed(input logic [7:0] b);
      req_word_type w;
      w.kind = REQ_FEED;
      w.data = b;
      w.idx  = IDX_W'($urandom_range(0, PAYLOAD_MAX - 1));
      return w;
   endfunction

   function automatic req_word_type mk_read(input int idx);
      req_word_type w;
      w.kind = REQ_READ;
      w.data = 8'($urandom_range(0, 255));
      w.idx  = IDX_W'(idx);
      return w;
   endfunction

   function automatic rsp_word_type mk_rsp(input logic rdy, input logic [7:0] typ,
                                           input logic [7:0] flg, input logic [7:0] seq,
                                           input int len, input int drops);
      rsp_word_type r;
      r = '0;
      r.frame_ready   = rdy;
      r.frame_type    = typ;
      r.frame_flags   = flg;
      r.frame_seq     = seq;
      r.payload_len   = LEN_W'(len);
      r.dropped_count = 32'(drops);
      return r;
   endfunction

   function automatic dir_row_type mk_row(input row_kind_type kind, input int arg,
                                          input logic typed, input rsp_word_type want);
      dir_row_type row;
      row.kind  = kind;
      row.arg   = 10'(arg);
      row.typed = typed;
      row.want  = want;
      return row;
   endfunction

   function automatic logic [7:0] pick_octet();
      logic [7:0] specials [4];
      specials = '{SLIP_END, SLIP_ESC, SLIP_ESC_END, SLIP_ESC_ESC};
      if ($urandom_range(99) < 25) begin
         return specials[$urandom_range(0, 3)];
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic send_word(input req_word_type w);
      while (!calm && $urandom_range(99) < 9) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= w.kind;
      req_bus.wire_byte  <= w.data;
      req_bus.read_index <= w.idx;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      words_sent++;
   endtask

   task automatic feed(input logic [7:0] b);
      int hi;
      send_word(mk_feed(b));
      // only read entries already written since reset
      if (reads_on && $urandom_range(99) < 8 && store_top > HDR_BYTES) begin
         hi = store_top - HDR_BYTES - 1;
         if (hi > PAYLOAD_MAX - 1) begin
            hi = PAYLOAD_MAX - 1;
         end
         send_word(mk_read($urandom_range(0, hi)));
      end
   endtask

   task automatic feed_content(input logic [7:0] b);
      if (b == SLIP_END) begin
         feed(SLIP_ESC);
         feed(SLIP_ESC_END);
      end else if (b == SLIP_ESC) begin
         feed(SLIP_ESC);
         feed(SLIP_ESC_ESC);
      end else begin
         feed(b);
      end
   endtask

   task automatic send_frame(input int plen, input fault_kind_type fault);
      logic [7:0]  body [$];
      logic [15:0] len_field, sum;
      logic [7:0]  junk;
      int          bad_at;
      if (fault == FAULT_SHORT) begin
         repeat ($urandom_range(1, 6)) body.push_back(pick_octet());
      end else begin
         len_field = 16'(plen);
         if (fault == FAULT_LEN) begin
            len_field = 16'(plen + $urandom_range(1, 3));
         end else if (fault == FAULT_BIG_LEN) begin
            len_field = 16'($urandom_range(PAYLOAD_MAX + 1, 16'hFFFF));
         end
         repeat (3) body.push_back(8'($urandom_range(0, 255)));
         body.push_back(len_field[7:0]);
         body.push_back(len_field[15:8]);
         repeat (plen) body.push_back(pick_octet());
         sum = crc_over(body);
         body.push_back(sum[7:0]);
         body.push_back(sum[15:8]);
         case (fault)
            FAULT_CRC: begin
               bad_at = body.size() - 1 - $urandom_range(0, 1);
               body[bad_at] = body[bad_at] ^ (8'h01 << $urandom_range(0, 7));
            end
            FAULT_TRUNC: begin
               repeat ($urandom_range(1, 3)) body.delete(body.size() - 1);
            end
            FAULT_EXTRA: begin
               body.push_back(pick_octet());
            end
            default: begin
            end
         endcase
      end
      bad_at = (fault == FAULT_BAD_ESC) ? $urandom_range(0, body.size() - 1) : -1;
      if ($urandom_range(99) < 20) begin
         feed(SLIP_END);
      end
      foreach (body[i]) begin
         if (i == bad_at) begin
            junk = 8'($urandom_range(0, 255));
            if (junk == SLIP_END || junk == SLIP_ESC_END || junk == SLIP_ESC_ESC) begin
               junk = 8'h00;
            end
            feed(SLIP_ESC);
            feed(junk);
         end
         feed_content(body[i]);
      end
      if (fault == FAULT_DANGLE) begin
         feed(SLIP_ESC);
      end
      feed(SLIP_END);
   endtask

   initial begin
      dir_row_type    dir_table [$];
      dir_row_type    row;
      logic [7:0]     tx_frame [$];
      logic [15:0]    sum;
      int             rand_base, pick, plen;
      bit             held;
      fault_kind_type fault;

      req_bus.valid      = 1'b0;
      req_bus.req_type   = REQ_FEED;
      req_bus.wire_byte  = '0;
      req_bus.read_index = '0;
      foreach (store_mem[i]) begin
         store_mem[i] = '0;
      end

      dir_table.push_back(mk_row(ROW_WIRE, SLIP_END, 1'b1,
                                 mk_rsp(1'b0, 8'h00, 8'h00, 8'h00, 0, 0)));
      dir_table.push_back(mk_row(ROW_WIRE, 8'h00, 1'b0, '0));
      dir_table.push_back(mk_row(ROW_WIRE, 8'hFF, 1'b0, '0));
      dir_table.push_back(mk_row(ROW_WIRE, SLIP_END, 1'b1,
                                 mk_rsp(1'b0, 8'h00, 8'h00, 8'h00, 0, 1)));
      dir_table.push_back(mk_row(ROW_WIRE, SLIP_ESC, 1'b0, '0));
      dir_table.push_back(mk_row(ROW_WIRE, SLIP_END, 1'b1,
                                 mk_rsp(1'b0, 8'h00, 8'h00, 8'h00, 0, 2)));
      dir_table.push_back(mk_row(ROW_WIRE, 8'h41, 1'b0, '0));
      dir_table.push_back(mk_row(ROW_WIRE, SLIP_ESC, 1'b0, '0));
      dir_table.push_back(mk_row(ROW_WIRE, 8'h00, 1'b0, '0));
      dir_table.push_back(mk_row(ROW_WIRE, 8'h55, 1'b0, '0));
      dir_table.push_back(mk_row(ROW_WIRE, SLIP_END, 1'b1,
                                 mk_rsp(1'b0, 8'h00, 8'h00, 8'h00, 0, 3)));
      // zero-length payload with both escape forms in the header
      dir_table.push_back(mk_row(ROW_DATA, SLIP_END, 1'b0, '0));
      dir_table.push_back(mk_row(ROW_DATA, SLIP_ESC, 1'b0, '0));
      dir_table.push_back(mk_row(ROW_DATA, 8'hFF, 1'b0, '0));
      dir_table.push_back(mk_row(ROW_DATA, 8'h00, 1'b0, '0));
      dir_table.push_back(mk_row(ROW_DATA, 8'h00, 1'b0, '0));
      dir_table.push_back(mk_row(ROW_CRC, 0, 1'b0, '0));
      dir_table.push_back(mk_row(ROW_WIRE, SLIP_END, 1'b1,
                                 mk_rsp(1'b1, SLIP_END, SLIP_ESC, 8'hFF, 0, 3)));
      dir_table.push_back(mk_row(ROW_READ, 0, 1'b0, '0));
      dir_table.push_back(mk_row(ROW_READ, 1, 1'b0, '0));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         row = dir_table[i];
         case (row.kind)
            ROW_WIRE: begin
               typed_on   = row.typed;
               typed_want = row.want;
               send_word(mk_feed(row.arg[7:0]));
               typed_on   = 1'b0;
               if (row.arg[7:0] == SLIP_END) begin
                  tx_frame.delete();
               end
            end
            ROW_DATA: begin
               tx_frame.push_back(row.arg[7:0]);
               feed_content(row.arg[7:0]);
            end
            ROW_CRC: begin
               sum = crc_over(tx_frame);
               feed_content(sum[7:0]);
               feed_content(sum[15:8]);
            end
            ROW_READ: begin
               send_word(mk_read(row.arg));
            end
            default: begin
            end
         endcase
      end

      // largest legal frame, then an overrun, with no idling on either side
      reads_on = 1'b1;
      calm     = 1'b1;
      send_frame(PAYLOAD_MAX, FAULT_NONE);
      send_word(mk_read(PAYLOAD_MAX - 1));
      send_word(mk_read(0));
      repeat (FRAME_BYTES + 6) feed_content(pick_octet());
      feed(SLIP_END);
      calm = 1'b0;

      rand_base = words_sent;
      held      = 1'b0;
      while (words_sent - rand_base < RANDOM_WORDS) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            pick = $urandom_range(99);
            plen = (pick < 80) ? $urandom_range(0, 16) :
                   (pick < 98) ? $urandom_range(17, 80) : $urandom_range(81, 300);
            fault = ($urandom_range(99) < 65) ? FAULT_NONE
                                              : fault_kind_type'($urandom_range(1, 8));
            send_frame(plen, fault);
         end else if (pick < 92) begin
            repeat ($urandom_range(1, 8)) feed(8'($urandom_range(0, 255)));
            feed(SLIP_END);
         end else begin
            feed(SLIP_END);
         end
         if (!held && words_sent - rand_base > RANDOM_WORDS / 2) begin
            hold_request = 1'b1;
            held         = 1'b1;
         end
      end
      req_bus.valid <= 1'b0;

      while (pending_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (faults == 0 && pending_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/scfd_pkg.sv
src/scfd_req_if.sv
src/scfd_rsp_if.sv
src/scfd_ram.sv
src/slip_crc_frame_decoder.sv
src/scfd_checker.sv
tb/testbench.sv
